// ----- design/toi_pkg.sv -----
// Shared constants and types for the three-wheel odometry integrator.
// Angle units, kinematic constants, stage latencies and register indexes.
// No dependencies.
package toi_pkg;

	localparam int HEADING_W  = 15;
	localparam int ANGLE_W    = 17;
	localparam int GAIN_W     = 24;
	localparam int POS_W      = 40;
	localparam int INC_W      = 42;
	localparam int SINE_W     = 17;

	localparam logic [ANGLE_W-1:0] FULL_TURN    = 17'd23040;
	localparam logic [ANGLE_W-1:0] QUARTER_TURN = 17'd5760;
	localparam logic [ANGLE_W-1:0] THIRD_TURN   = 17'd7680;

	// 2/(3*sqrt(3)) in Q24
	localparam logic [22:0] INV_K_Q24 = 23'd6457553;
	// ceil(2^24/45), exact floor divide by 45 below 381300
	localparam logic [18:0] RECIP_45  = 19'd372828;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DEN [10] =
		'{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

	localparam int SINE_LAT  = 6;
	localparam int LANE_LAT  = SINE_LAT + 1;
	localparam int MERGE_LAT = 6;
	localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t REG_MOUNT_OFFSET   = 1'b0;
	localparam cfg_index_t REG_PER_COUNT_GAIN = 1'b1;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [INC_W-1:0] inc_t;

endpackage

// ----- design/toi_ifaces.sv -----
// Handshake channels of the odometry integrator: tick words in, position words out.
// Depends on toi_pkg.
interface toi_tick_if #(parameter int COUNT_WIDTH = 16);
	import toi_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [COUNT_WIDTH-1:0] count_one;
	logic signed [COUNT_WIDTH-1:0] count_two;
	logic signed [COUNT_WIDTH-1:0] count_three;
	logic [HEADING_W-1:0]          heading;
	modport source (output valid, count_one, count_two, count_three, heading, input ready);
	modport sink (input valid, count_one, count_two, count_three, heading, output ready);
endinterface

interface toi_pos_if;
	import toi_pkg::*;
	logic valid;
	logic ready;
	pos_t x_position;
	pos_t y_position;
	modport source (output valid, x_position, y_position, input ready);
	modport sink (input valid, x_position, y_position, output ready);
endinterface

// ----- design/toi_sine_rom.sv -----
// Quarter-wave sine table in Q15, built at elaboration, registered read.
// Depends on toi_pkg.
module toi_sine_rom #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic [AW-1:0] addr,
	output logic [15:0]   data
);
	import toi_pkg::*;

	typedef logic [15:0] rom_t [DEPTH];

	// sin(i*pi/(2*DEPTH)) by integer Taylor series on a Q30 argument
	function automatic rom_t build_rom();
		rom_t              r;
		logic [63:0]       x;
		logic [63:0]       x2;
		logic [63:0]       term;
		logic signed [63:0] sum;
		for (int i = 0; i < DEPTH; i++) begin
			x    = (64'(i) * HALF_PI_Q30 + 64'(DEPTH / 2)) / 64'(DEPTH);
			x2   = (x * x) >> 30;
			term = x;
			sum  = $signed(x);
			for (int k = 1; k <= 10; k++) begin
				term = ((term * x2) >> 30) / TAYLOR_DEN[k-1];
				if (k % 2 == 1) sum = sum - $signed(term);
				else sum = sum + $signed(term);
			end
			if (sum < 0) sum = '0;
			r[i] = 16'(($unsigned(sum) + 64'd16384) >> 15);
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	always_ff @(posedge clk) begin
		if ({1'b0, addr} < (AW+1)'(DEPTH)) data <= ROM[addr];
		else data <= '0;
	end

endmodule

// ----- design/toi_sine.sv -----
// Sine of an angle in 1/64 degree: turn reduction, quadrant fold, table index, sign.
// Six-stage pipeline. Depends on toi_pkg and toi_sine_rom.
module toi_sine #(
	parameter int DEPTH = 1024
) (
	input  logic                        clk,
	input  logic [toi_pkg::ANGLE_W-1:0] angle,
	output logic signed [toi_pkg::SINE_W-1:0] value
);
	import toi_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [ANGLE_W-1:0] a_red;
	logic [14:0]        a_s1;
	logic [1:0]         q_c;
	logic [12:0]        r_c;
	logic [1:0]         q_s2, q_s3, q_s4, q_s5;
	logic [12:0]        r_s2;
	logic [31:0]        rd;
	logic [17:0]        v_s3;
	logic [36:0]        p;
	logic [12:0]        idx_s4;
	logic [15:0]        mag_s5;
	logic               full_s5;
	logic [SINE_W-1:0]  m17;

	// angle is below four turns
	always_comb begin
		if (angle >= 17'(3 * FULL_TURN)) a_red = angle - 17'(3 * FULL_TURN);
		else if (angle >= 17'(2 * FULL_TURN)) a_red = angle - 17'(2 * FULL_TURN);
		else if (angle >= FULL_TURN) a_red = angle - FULL_TURN;
		else a_red = angle;
	end

	always_ff @(posedge clk) a_s1 <= a_red[14:0];

	always_comb begin
		logic [ANGLE_W-1:0] a17;
		logic [ANGLE_W-1:0] r17;
		a17 = 17'(a_s1);
		if (a17 >= 17'(3 * QUARTER_TURN)) begin
			q_c = 2'd3; r17 = a17 - 17'(3 * QUARTER_TURN);
		end else if (a17 >= 17'(2 * QUARTER_TURN)) begin
			q_c = 2'd2; r17 = a17 - 17'(2 * QUARTER_TURN);
		end else if (a17 >= QUARTER_TURN) begin
			q_c = 2'd1; r17 = a17 - QUARTER_TURN;
		end else begin
			q_c = 2'd0; r17 = a17;
		end
		if (q_c[0]) r17 = QUARTER_TURN - r17;
		r_c = r17[12:0];
	end

	always_ff @(posedge clk) begin
		q_s2 <= q_c;
		r_s2 <= r_c;
	end

	// index = floor(r*DEPTH/5760) = floor(floor(r*DEPTH/128)/45)
	assign rd = 32'(r_s2) * 32'(DEPTH);

	always_ff @(posedge clk) begin
		v_s3 <= rd[24:7];
		q_s3 <= q_s2;
	end

	assign p = 37'(v_s3) * 37'(RECIP_45);

	always_ff @(posedge clk) begin
		idx_s4 <= p[36:24];
		q_s4   <= q_s3;
	end

	toi_sine_rom #(.DEPTH(DEPTH)) u_rom (
		.clk  (clk),
		.addr (idx_s4[AW-1:0]),
		.data (mag_s5)
	);

	always_ff @(posedge clk) begin
		full_s5 <= (idx_s4 >= 13'(DEPTH));
		q_s5    <= q_s4;
	end

	assign m17 = full_s5 ? 17'd32768 : {1'b0, mag_s5};

	always_ff @(posedge clk) value <= q_s5[1] ? -$signed(m17) : $signed(m17);

endmodule

// ----- design/toi_lane.sv -----
// One wheel lane: sine and cosine of the wheel angle times its count difference.
// Depends on toi_pkg and toi_sine.
module toi_lane #(
	parameter int DEPTH       = 1024,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic [toi_pkg::ANGLE_W-1:0]  angle,
	input  logic signed [COUNT_WIDTH:0]  diff,
	output logic signed [COUNT_WIDTH+17:0] sin_prod,
	output logic signed [COUNT_WIDTH+17:0] cos_prod
);
	import toi_pkg::*;

	localparam int PW = COUNT_WIDTH + 18;

	logic signed [SINE_W-1:0] sin_v;
	logic signed [SINE_W-1:0] cos_v;

	toi_sine #(.DEPTH(DEPTH)) u_sin (.clk(clk), .angle(angle), .value(sin_v));
	toi_sine #(.DEPTH(DEPTH)) u_cos (.clk(clk), .angle(angle + QUARTER_TURN), .value(cos_v));

	always_ff @(posedge clk) begin
		sin_prod <= PW'(sin_v) * PW'(diff);
		cos_prod <= PW'(cos_v) * PW'(diff);
	end

endmodule

// ----- design/toi_merge.sv -----
// Merges the three lane products of one axis and scales them to a position step:
// gain multiply and 1/k multiply, each cut in two partial products, rounded half away.
// Depends on toi_pkg.
module toi_merge #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                           clk,
	input  logic [toi_pkg::GAIN_W-1:0]     gain,
	input  logic signed [COUNT_WIDTH+17:0] p_one,
	input  logic signed [COUNT_WIDTH+17:0] p_two,
	input  logic signed [COUNT_WIDTH+17:0] p_three,
	output toi_pkg::inc_t                  inc
);
	import toi_pkg::*;

	localparam int NW  = COUNT_WIDTH + 20;
	localparam int PW  = NW + 25;
	localparam int AW2 = NW + 2;
	localparam int HW  = AW2 - 26 + 23;
	localparam int QW  = AW2 + 24;

	logic signed [NW-1:0] sum_s1;
	logic [NW-1:0]        mag_s2;
	logic                 neg_s2, neg_s3, neg_s4, neg_s5;
	logic [47:0]          pl_s3;
	logic [NW-1:0]        ph_s3;
	logic [PW-1:0]        pt;
	logic [AW2-1:0]       a_s4;
	logic [48:0]          ql_s5;
	logic [HW-1:0]        qh_s5;
	logic [QW-1:0]        qt;
	logic [63:0]          step;
	logic [40:0]          step_c;

	always_ff @(posedge clk) begin
		sum_s1 <= NW'(p_one) + NW'(p_two) + NW'(p_three);
		neg_s2 <= sum_s1[NW-1];
		mag_s2 <= sum_s1[NW-1] ? $unsigned(-sum_s1) : $unsigned(sum_s1);
		pl_s3  <= 48'(mag_s2[23:0]) * 48'(gain);
		ph_s3  <= NW'(mag_s2[NW-1:24]) * NW'(gain);
		neg_s3 <= neg_s2;
	end

	assign pt = PW'(pl_s3) + (PW'(ph_s3) << 24) + (PW'(1) << 22);

	always_ff @(posedge clk) begin
		a_s4   <= pt[PW-1:23];
		neg_s4 <= neg_s3;
		ql_s5  <= 49'(a_s4[25:0]) * 49'(INV_K_Q24);
		qh_s5  <= HW'(a_s4[AW2-1:26]) * HW'(INV_K_Q24);
		neg_s5 <= neg_s4;
	end

	assign qt   = QW'(ql_s5) + (QW'(qh_s5) << 26) + (QW'(1) << 31);
	assign step = 64'(qt[QW-1:32]);
	// step is held to 2^40 before the accumulator
	assign step_c = (step > (64'd1 << 40)) ? (41'd1 << 40) : step[40:0];

	always_ff @(posedge clk) inc <= neg_s5 ? -$signed(INC_W'(step_c)) : $signed(INC_W'(step_c));

endmodule

// ----- design/three_wheel_odometry_integrator.sv -----
// Three-wheel omni odometry integrator. Each tick word (three encoder counts and a
// heading) updates the saturating x/y position accumulators and yields one position
// word. A position word is offered once its tick has passed the wheel lanes (angle
// reduction, table lookup, product), the scaling merge and the commit into the
// accumulators. One tick is in flight at a time; the next is taken the cycle after
// the commit, even while the last position word still waits. A waiting word holds
// off the commit of the following tick. Configuration writes need no wait.
// Depends on toi_pkg, toi_ifaces, toi_lane and toi_merge.
module three_wheel_odometry_integrator #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int COUNT_WIDTH      = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	toi_tick_if.sink                    tick,
	toi_pos_if.source                   position,
	input  logic                        cfg_wr_en,
	input  toi_pkg::cfg_index_t         cfg_index,
	input  logic [toi_pkg::GAIN_W-1:0]  cfg_data
);
	import toi_pkg::*;

	localparam int CNTW = $clog2(TOTAL_LAT + 1);
	localparam int PW   = COUNT_WIDTH + 18;

	logic [HEADING_W-1:0]        mount_q;
	logic [GAIN_W-1:0]           gain_q;
	logic                        busy_q;
	logic [CNTW-1:0]             cnt_q;
	logic                        valid_q;
	pos_t                        x_acc_q, y_acc_q;
	logic [ANGLE_W-1:0]          angle_q [3];
	logic signed [COUNT_WIDTH:0] diff_q [3];
	logic signed [PW-1:0]        sin_p [3];
	logic signed [PW-1:0]        cos_p [3];
	inc_t                        dx, dy;
	pos_t                        x_next, y_next;
	logic                        accept, commit;

	function automatic pos_t sat_add(pos_t acc, inc_t step);
		logic signed [INC_W:0] s;
		s = (INC_W+1)'(acc) + (INC_W+1)'(step);
		if (s > (INC_W+1)'(signed'({1'b0, {(POS_W-1){1'b1}}}))) return {1'b0, {(POS_W-1){1'b1}}};
		if (s < -((INC_W+1)'(1) <<< (POS_W-1))) return {1'b1, {(POS_W-1){1'b0}}};
		return s[POS_W-1:0];
	endfunction

	assign tick.ready = !busy_q;
	assign accept     = tick.valid && !busy_q;
	assign commit     = busy_q && (cnt_q == '0) && (!valid_q || position.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_q <= 15'd1920;
			gain_q  <= 24'd1284929;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MOUNT_OFFSET:   mount_q <= cfg_data[HEADING_W-1:0];
				REG_PER_COUNT_GAIN: gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// wheel angles and count differences held for the whole tick
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++)
				angle_q[i] <= 17'(tick.heading) + 17'(mount_q) + 17'(i) * THIRD_TURN;
			diff_q[0] <= (COUNT_WIDTH+1)'(tick.count_three) - (COUNT_WIDTH+1)'(tick.count_two);
			diff_q[1] <= (COUNT_WIDTH+1)'(tick.count_one) - (COUNT_WIDTH+1)'(tick.count_three);
			diff_q[2] <= (COUNT_WIDTH+1)'(tick.count_two) - (COUNT_WIDTH+1)'(tick.count_one);
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		toi_lane #(.DEPTH(SINE_TABLE_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_lane (
			.clk      (clk),
			.angle    (angle_q[g]),
			.diff     (diff_q[g]),
			.sin_prod (sin_p[g]),
			.cos_prod (cos_p[g])
		);
	end

	toi_merge #(.COUNT_WIDTH(COUNT_WIDTH)) u_merge_x (
		.clk(clk), .gain(gain_q),
		.p_one(cos_p[0]), .p_two(cos_p[1]), .p_three(cos_p[2]), .inc(dx)
	);

	toi_merge #(.COUNT_WIDTH(COUNT_WIDTH)) u_merge_y (
		.clk(clk), .gain(gain_q),
		.p_one(sin_p[0]), .p_two(sin_p[1]), .p_three(sin_p[2]), .inc(dy)
	);

	assign x_next = sat_add(x_acc_q, dx);
	assign y_next = sat_add(y_acc_q, dy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
			x_acc_q <= '0;
			y_acc_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(TOTAL_LAT);
			end else if (busy_q && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				valid_q <= 1'b1;
				x_acc_q <= x_next;
				y_acc_q <= y_next;
			end else if (position.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign position.valid      = valid_q;
	assign position.x_position = x_acc_q;
	assign position.y_position = y_acc_q;

endmodule
